// ----- rtl/pvmv_pkg.sv -----
// Package with shared widths, constants and control types of the majority vote block.
`timescale 1ns / 1ps
`default_nettype none

package pvmv_pkg;

   localparam int MAX_VERTICES_DEF = 4096;
   localparam int MAX_LABELS_DEF   = 64;
   localparam int COUNT_MAX_DEF    = 255;

   localparam int VERTEX_W       = 12;
   localparam int LABEL_W        = 6;
   localparam int COUNT_OUT_W    = 8;
   localparam int NUM_LABELS_W   = 7;
   localparam int NUM_VERTICES_W = 13;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 32;
   localparam int REQ_PAD_W   = REQ_TDATA_W - VERTEX_W - LABEL_W - 1;
   localparam int RSP_PAD_W   = RSP_TDATA_W - VERTEX_W - LABEL_W - COUNT_OUT_W;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = NUM_VERTICES_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_LABELS   = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_VERTICES = CSR_INDEX_W'(1);

   localparam logic [NUM_LABELS_W-1:0]   NUM_LABELS_RST   = NUM_LABELS_W'(64);
   localparam logic [NUM_VERTICES_W-1:0] NUM_VERTICES_RST = NUM_VERTICES_W'(4096);

   localparam logic REQ_VOTE  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_OUT_RANGE = 1'b1;

   typedef struct packed {
      logic clear;
      logic accept;
      logic vote_write;
      logic scan;
      logic result;
   } pvmv_cmd_type;

   typedef struct packed {
      logic in_query;
      logic in_vertex_ok;
      logic scan_last;
      logic clear_last;
      logic rsp_free;
   } pvmv_status_type;

endpackage

`default_nettype wire

// ----- rtl/per_vertex_majority_vote_top.sv -----
// Top level of the per-vertex majority vote block with its configuration registers.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps one saturating vote counter per vertex and label in a single-port
// style memory of MAX_VERTICES * MAX_LABELS entries. After reset it runs a clearing
// pass that writes one entry per cycle, and no beat is accepted until that pass ends;
// configuration writes are taken at any time. A vote beat reads its counter and then
// writes it back, incremented, if the vote is valid. A query beat in range reads
// one counter per label for max(min(num_labels, MAX_LABELS), 1) labels, and an
// out-of-range query goes straight to its result; a query also waits while the
// previous result beat is still held in the output register.
module per_vertex_majority_vote_top #(
   parameter int MAX_VERTICES = pvmv_pkg::MAX_VERTICES_DEF,
   parameter int MAX_LABELS   = pvmv_pkg::MAX_LABELS_DEF,
   parameter int COUNT_MAX    = pvmv_pkg::COUNT_MAX_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // vertex[11:0], label_index[17:12], label_found[18], zero[23:19]
   input  wire [pvmv_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // req_type[0]
   input  wire                                  req_tuser,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // vertex_out[11:0], winner_label[17:12], winner_count[25:18], zero[31:26]
   output logic [pvmv_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // status[0]
   output logic                                 rsp_tuser,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire [pvmv_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire [pvmv_pkg::CSR_DATA_W-1:0]       csr_data
);
   import pvmv_pkg::*;

   logic [NUM_LABELS_W-1:0]   num_labels_ff, num_labels_in;
   logic [NUM_VERTICES_W-1:0] num_vertices_ff, num_vertices_in;

   pvmv_cmd_type    cmd;
   pvmv_status_type status;

   assign csr_ready = 1'b1;

   always_comb begin
      num_labels_in   = num_labels_ff;
      num_vertices_in = num_vertices_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_NUM_LABELS:   num_labels_in   = csr_data[NUM_LABELS_W-1:0];
            CSR_NUM_VERTICES: num_vertices_in = csr_data[NUM_VERTICES_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_labels_ff   <= NUM_LABELS_RST;
         num_vertices_ff <= NUM_VERTICES_RST;
      end else begin
         num_labels_ff   <= num_labels_in;
         num_vertices_ff <= num_vertices_in;
      end
   end

   pvmv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pvmv_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_LABELS   (MAX_LABELS),
      .COUNT_MAX    (COUNT_MAX)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .num_labels   (num_labels_ff),
      .num_vertices (num_vertices_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

endmodule

`default_nettype wire

// ----- rtl/pvmv_ctrl.sv -----
// Controller state machine that sequences clearing, votes and label scans.
`timescale 1ns / 1ps
`default_nettype none

module pvmv_ctrl (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  pvmv_pkg::pvmv_status_type    status,
   output pvmv_pkg::pvmv_cmd_type       cmd
);
   import pvmv_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_VOTE   = 5'b00100,
      ST_SCAN   = 5'b01000,
      ST_RESULT = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_tready     = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (!status.in_query) begin
                  state_in = ST_VOTE;
               end else if (status.in_vertex_ok) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_RESULT;
               end
            end
         end
         ST_VOTE: begin
            cmd.vote_write = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (status.rsp_free) begin
               cmd.result = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/pvmv_datapath.sv -----
// Datapath with the counter memory, address and scan registers, and the result register.
`timescale 1ns / 1ps
`default_nettype none

module pvmv_datapath #(
   parameter int MAX_VERTICES = pvmv_pkg::MAX_VERTICES_DEF,
   parameter int MAX_LABELS   = pvmv_pkg::MAX_LABELS_DEF,
   parameter int COUNT_MAX    = pvmv_pkg::COUNT_MAX_DEF
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  pvmv_pkg::pvmv_cmd_type                  cmd,
   output pvmv_pkg::pvmv_status_type               status,
   input  wire [pvmv_pkg::REQ_TDATA_W-1:0]         req_tdata,
   input  wire                                     req_tuser,
   input  wire [pvmv_pkg::NUM_LABELS_W-1:0]        num_labels,
   input  wire [pvmv_pkg::NUM_VERTICES_W-1:0]      num_vertices,
   output logic                                    rsp_tvalid,
   input  wire                                     rsp_tready,
   output logic [pvmv_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   output logic                                    rsp_tuser
);
   import pvmv_pkg::*;

   localparam int Depth = MAX_VERTICES * MAX_LABELS;
   localparam int AW    = $clog2(Depth);
   localparam int CW    = $clog2(COUNT_MAX + 1);
   localparam int LIW   = $clog2(MAX_LABELS);

   logic [CW-1:0] mem [Depth];

   logic [VERTEX_W-1:0] in_vertex;
   logic [LABEL_W-1:0]  in_label;
   logic                in_found;
   logic [LABEL_W-1:0]  in_label_sel;
   logic [AW-1:0]       in_addr;
   logic                in_vote_ok;

   logic [AW-1:0]       addr_ff, addr_in;
   logic [LIW-1:0]      idx_ff, idx_in;
   logic [VERTEX_W-1:0] vertex_ff, vertex_in;
   logic                vote_ok_ff, vote_ok_in;
   logic                oor_ff, oor_in;
   logic [LIW-1:0]      best_label_ff, best_label_in;
   logic [CW-1:0]       best_cnt_ff, best_cnt_in;
   logic [CW-1:0]       rd_data_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [VERTEX_W-1:0] rsp_vertex_ff, rsp_vertex_in;
   logic [LIW-1:0]      rsp_label_ff, rsp_label_in;
   logic [CW-1:0]       rsp_count_ff, rsp_count_in;
   logic                rsp_status_ff, rsp_status_in;

   logic [AW-1:0]       addr_next;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic                wr_en;
   logic [CW-1:0]       wr_data;
   logic [31:0]         idx_next_wide;

   assign in_vertex    = req_tdata[VERTEX_W-1:0];
   assign in_label     = req_tdata[VERTEX_W+LABEL_W-1:VERTEX_W];
   assign in_found     = req_tdata[VERTEX_W+LABEL_W];
   assign in_label_sel = (req_tuser == REQ_QUERY) ? '0 : in_label;
   assign in_addr      = AW'(32'(in_vertex) * 32'(MAX_LABELS) + 32'(in_label_sel));

   assign status.in_query     = (req_tuser == REQ_QUERY);
   assign status.in_vertex_ok = (32'(in_vertex) < 32'(num_vertices)) &&
                                (32'(in_vertex) < 32'(MAX_VERTICES));
   assign in_vote_ok          = status.in_vertex_ok && in_found &&
                                (32'(in_label) < 32'(num_labels)) &&
                                (32'(in_label) < 32'(MAX_LABELS));

   assign idx_next_wide     = 32'(idx_ff) + 32'd1;
   assign status.scan_last  = (idx_next_wide >= 32'(num_labels)) ||
                              (idx_next_wide >= 32'(MAX_LABELS));
   assign status.clear_last = (addr_ff == AW'(Depth - 1));
   assign status.rsp_free   = !rsp_valid_ff || rsp_tready;

   assign addr_next = addr_ff + AW'(1);
   assign rd_en     = cmd.accept || (cmd.scan && !status.scan_last);
   assign rd_addr   = cmd.accept ? in_addr : addr_next;
   assign wr_en     = cmd.clear || (cmd.vote_write && vote_ok_ff);
   assign wr_data   = cmd.clear ? '0 :
                      (rd_data_ff < CW'(COUNT_MAX)) ? rd_data_ff + CW'(1) : rd_data_ff;

   always_comb begin
      addr_in       = addr_ff;
      idx_in        = idx_ff;
      vertex_in     = vertex_ff;
      vote_ok_in    = vote_ok_ff;
      oor_in        = oor_ff;
      best_label_in = best_label_ff;
      best_cnt_in   = best_cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_label_in  = rsp_label_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;

      if (cmd.clear) begin
         addr_in = status.clear_last ? '0 : addr_next;
      end
      if (cmd.accept) begin
         addr_in       = in_addr;
         idx_in        = '0;
         vertex_in     = in_vertex;
         vote_ok_in    = in_vote_ok;
         oor_in        = !status.in_vertex_ok;
         best_label_in = '0;
         best_cnt_in   = '0;
      end
      if (cmd.scan) begin
         if ((idx_ff == '0) || (rd_data_ff > best_cnt_ff)) begin
            best_label_in = idx_ff;
            best_cnt_in   = rd_data_ff;
         end
         if (!status.scan_last) begin
            addr_in = addr_next;
            idx_in  = idx_ff + LIW'(1);
         end
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.result) begin
         rsp_valid_in  = 1'b1;
         rsp_vertex_in = vertex_ff;
         rsp_label_in  = best_label_ff;
         rsp_count_in  = best_cnt_ff;
         rsp_status_in = oor_ff ? STATUS_OUT_RANGE : STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         addr_ff      <= addr_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vertex_ff     <= vertex_in;
      vote_ok_ff    <= vote_ok_in;
      oor_ff        <= oor_in;
      best_label_ff <= best_label_in;
      best_cnt_ff   <= best_cnt_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_label_ff  <= rsp_label_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, COUNT_OUT_W'(rsp_count_ff),
                        LABEL_W'(rsp_label_ff), rsp_vertex_ff};

endmodule

`default_nettype wire
